FILE: rtl/core/spq_pkg.sv
// spq_pkg: shared types and defaults for the sorted priority queue
// no dependencies; used by spq_slots and sorted_priority_queue_top
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int TAG_WIDTH_DEF  = 16;
    localparam int PRIO_WIDTH_DEF = 8;

    // command carried on the input tuser bit
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    // operation handed to the slot array
    typedef struct packed {
        logic en;
        cmd_t cmd;
    } op_t;

    // per-item status flags
    typedef struct packed {
        logic overflow;
        logic underflow;
        logic removed_valid;
    } status_t;

endpackage

FILE: rtl/core/spq_slots.sv
// spq_slots: sorted slot array with parallel compare and shift, plus fill count
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_slots #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int TAG_WIDTH  = spq_pkg::TAG_WIDTH_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  spq_pkg::op_t          op,
    input  logic [TAG_WIDTH-1:0]  tag,
    input  logic [PRIO_WIDTH-1:0] prio,
    output spq_pkg::status_t      status,
    output logic [TAG_WIDTH-1:0]  head_tag,
    output logic [PRIO_WIDTH-1:0] head_prio,
    output logic [CNT_W-1:0]      count_after,
    output logic [CNT_W-1:0]      count
);

    logic [TAG_WIDTH-1:0]  tag_reg  [DEPTH];
    logic [PRIO_WIDTH-1:0] prio_reg [DEPTH];
    logic [TAG_WIDTH-1:0]  tag_next [DEPTH];
    logic [PRIO_WIDTH-1:0] prio_next[DEPTH];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [DEPTH-1:0]      after;
    logic                  full;
    logic                  empty;
    logic                  do_ins;
    logic                  do_rem;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_ins = op.en && (op.cmd == spq_pkg::CMD_INSERT) && !full;
    assign do_rem = op.en && (op.cmd == spq_pkg::CMD_REMOVE) && !empty;

    // new entry goes behind every occupied slot of equal or lower number
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_slot
            assign after[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] <= prio);

            always_comb
            begin
                tag_next[i]  = tag_reg[i];
                prio_next[i] = prio_reg[i];
                if (do_ins && !after[i])
                begin
                    if (i == 0)
                    begin
                        tag_next[i]  = tag;
                        prio_next[i] = prio;
                    end
                    else if (after[(i == 0) ? 0 : i - 1])
                    begin
                        tag_next[i]  = tag;
                        prio_next[i] = prio;
                    end
                    else
                    begin
                        tag_next[i]  = tag_reg[(i == 0) ? 0 : i - 1];
                        prio_next[i] = prio_reg[(i == 0) ? 0 : i - 1];
                    end
                end
                else if (do_rem && (i < DEPTH - 1))
                begin
                    tag_next[i]  = tag_reg[(i < DEPTH - 1) ? i + 1 : i];
                    prio_next[i] = prio_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end

            always_ff @(posedge clk)
            begin
                tag_reg[i]  <= tag_next[i];
                prio_reg[i] <= prio_next[i];
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CNT_W'(1);
        else if (do_rem)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign status.removed_valid = do_rem;
    assign status.underflow     = op.en && (op.cmd == spq_pkg::CMD_REMOVE) && empty;
    assign status.overflow      = op.en && (op.cmd == spq_pkg::CMD_INSERT) && full;
    assign head_tag    = do_rem ? tag_reg[0]  : '0;
    assign head_prio   = do_rem ? prio_reg[0] : '0;
    assign count_after = count_next;
    assign count       = count_reg;

endmodule

FILE: rtl/core/sorted_priority_queue_top.sv
// sorted_priority_queue_top: stream wrapper with input and result registers
// depends on spq_pkg and spq_slots
`timescale 1ns / 1ps

// Bounded priority queue of DEPTH entries kept sorted by ascending priority
// number, head in slot 0. Each input item is an insert (tuser = 0) of a tag
// and priority, or a removal of the head (tuser = 1). An insert lands behind
// every stored entry of equal or lower number, so equal priorities leave in
// arrival order. Every item yields exactly one result item carrying the
// removed head (or zeros), underflow / overflow flags and the fill count after
// the item. An insert into a full queue is dropped and flagged as overflow.
// Throughput is one item per clock while the result channel does not stall:
// every slot compares against the new priority in parallel and shifts by at
// most one place, so the whole update is combinational between the input
// register and the result register. An accepted item is held in the input
// register, and its result in the result register, before the result is offered.
// Storage is one register row per slot; slot contents need no reset since only
// slots below the fill count are ever read.

module sorted_priority_queue_top #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int TAG_WIDTH  = spq_pkg::TAG_WIDTH_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int IN_DATA_W  = ((TAG_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((TAG_WIDTH + PRIO_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input item channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // job_tag, prio_value, zero pad
    input  logic [0:0]            s_tuser,   // cmd
    // result item channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // removed_tag, removed_prio, entry_count, zero pad
    output logic [2:0]            m_tuser    // removed_valid, underflow, overflow
);

    // input register
    logic                  in_vld_reg;
    spq_pkg::cmd_t         in_cmd_reg;
    logic [TAG_WIDTH-1:0]  in_tag_reg;
    logic [PRIO_WIDTH-1:0] in_prio_reg;

    // result register
    logic                  out_vld_reg;
    logic                  out_vld_next;
    spq_pkg::status_t      out_status_reg;
    logic [TAG_WIDTH-1:0]  out_tag_reg;
    logic [PRIO_WIDTH-1:0] out_prio_reg;
    logic [CNT_W-1:0]      out_count_reg;

    // slot array results
    spq_pkg::op_t          op;
    spq_pkg::status_t      status;
    logic [TAG_WIDTH-1:0]  head_tag;
    logic [PRIO_WIDTH-1:0] head_prio;
    logic [CNT_W-1:0]      count_after;
    logic [CNT_W-1:0]      count;

    logic                  in_acc;
    logic                  advance;

    // the held item moves on whenever the result register is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_cmd_reg  <= spq_pkg::cmd_t'(s_tuser[0]);
            in_tag_reg  <= s_tdata[TAG_WIDTH-1:0];
            in_prio_reg <= s_tdata[TAG_WIDTH+PRIO_WIDTH-1:TAG_WIDTH];
        end
    end

    assign op.en  = advance;
    assign op.cmd = in_cmd_reg;

    spq_slots #(
        .DEPTH      (DEPTH),
        .TAG_WIDTH  (TAG_WIDTH),
        .PRIO_WIDTH (PRIO_WIDTH),
        .CNT_W      (CNT_W)
    ) u_slots (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .tag         (in_tag_reg),
        .prio        (in_prio_reg),
        .status      (status),
        .head_tag    (head_tag),
        .head_prio   (head_prio),
        .count_after (count_after),
        .count       (count)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status;
            out_tag_reg    <= head_tag;
            out_prio_reg   <= head_prio;
            out_count_reg  <= count_after;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = OUT_DATA_W'({out_count_reg, out_prio_reg, out_tag_reg});
    assign m_tuser[0] = out_status_reg.removed_valid;
    assign m_tuser[1] = out_status_reg.underflow;
    assign m_tuser[2] = out_status_reg.overflow;

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // an overflow result only ever reports a full queue
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg.overflow) |-> (out_count_reg == CNT_W'(DEPTH)))
        else $error("overflow reported with room left");

    // an accepted insert into a non-full queue grows the count by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_cmd_reg == spq_pkg::CMD_INSERT) && (count != CNT_W'(DEPTH)))
        |=> (count == $past(count) + CNT_W'(1)))
        else $error("insert did not grow the queue");

    // a result never carries more than one flag
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tuser))
        else $error("conflicting result flags");

endmodule
